/* rtl/vha_pkg.sv */
// Shared types, codes and the handle packing function of the handle allocator.
package vha_pkg;

	localparam int HANDLE_W = 32;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_STALE = 2'd2;

	localparam logic KIND_CREATE  = 1'b0;
	localparam logic KIND_DESTROY = 1'b1;

	// command classes decided in the front end
	typedef enum logic [1:0] {
		OP_CREATE,
		OP_DESTROY,
		OP_STALE
	} op_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_POP,
		BS_CHECK
	} bstate_t;

	typedef struct packed {
		op_t                 op;
		logic [HANDLE_W-1:0] handle;
	} cmd_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [STATUS_W-1:0] status;
	} res_t;

	// index in the low ib bits, version above, truncated to the handle width
	function automatic logic [HANDLE_W-1:0] make_handle(logic [31:0] idx, logic [31:0] ver,
			int ib, int vb);
		logic [63:0] m_i;
		logic [63:0] m_v;
		logic [63:0] h;
		m_i = (64'd1 << ib) - 64'd1;
		m_v = (64'd1 << vb) - 64'd1;
		h   = ({32'd0, idx} & m_i) | (({32'd0, ver} & m_v) << ib);
		return h[HANDLE_W-1:0];
	endfunction

endpackage

/* rtl/versioned_handle_allocator.sv */
// Top level of the versioned handle allocator: front end, command queue, back end, result queue.
//
//  channel   | direction | handshake                  | beat contents
//  ----------+-----------+----------------------------+---------------------------
//  request   | in        | push / full  (push & !full)| kind, handle_in
//  result    | out       | empty / pop  (pop & !empty)| handle_out, status
//
//  Sequencing: the back end serves a create that reuses a freed slot in BS_IDLE (free stack
//  read) and BS_POP (slot write), and a destroy that names an existing slot in BS_IDLE
//  (slot read) and BS_CHECK (compare and write); append, table-full and stale answers
//  come straight from BS_IDLE. The single read port of each memory and the one-command
//  sequencer set this split; no new command is taken until the current one is answered.
//  Reset clears counters, queues and sequencer; slot and stack memories are not cleared,
//  since an entry is never read before it is written. A full result queue holds the back
//  end; the command queue then fills and full rises toward the requester.
module versioned_handle_allocator #(
	parameter int MAX_SLOTS    = 1024,
	parameter int INDEX_BITS   = 16,
	parameter int VERSION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [31:0] handle_in,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] handle_out,
	output logic [1:0]  status
);
	import vha_pkg::*;

	// front end to command queue
	logic fe_push;
	cmd_t fe_cmd;
	logic cq_full;

	// command queue to back end
	logic cq_empty;
	logic cq_pop;
	cmd_t cq_cmd;
	logic [$bits(cmd_t)-1:0] cq_rdata;

	// back end to result queue
	logic be_push;
	res_t be_res;
	logic rq_full;
	logic [$bits(res_t)-1:0] rq_rdata;
	res_t rq_res;

	vha_front #(
		.MAX_SLOTS    (MAX_SLOTS),
		.INDEX_BITS   (INDEX_BITS),
		.VERSION_BITS (VERSION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.handle_in (handle_in),
		.cmd_push  (fe_push),
		.cmd_data  (fe_cmd),
		.cmd_full  (cq_full)
	);

	// short queue that decouples classification from execution
	vha_fifo #(
		.WIDTH ($bits(cmd_t))
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.wdata  (fe_cmd),
		.full   (cq_full),
		.pop    (cq_pop),
		.rdata  (cq_rdata),
		.empty  (cq_empty)
	);

	assign cq_cmd = cmd_t'(cq_rdata);

	vha_back #(
		.MAX_SLOTS    (MAX_SLOTS),
		.INDEX_BITS   (INDEX_BITS),
		.VERSION_BITS (VERSION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cq_empty),
		.cmd_data  (cq_cmd),
		.cmd_pop   (cq_pop),
		.res_push  (be_push),
		.res_data  (be_res),
		.res_full  (rq_full)
	);

	// result queue: finished beats wait here while the back end moves on
	vha_fifo #(
		.WIDTH ($bits(res_t))
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (be_push),
		.wdata  (be_res),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign rq_res     = res_t'(rq_rdata);
	assign handle_out = rq_res.handle;
	assign status     = rq_res.status;

endmodule

/* rtl/vha_fifo.sv */
// Two-entry queue used between front and back and on the result side.
module vha_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

/* rtl/vha_front.sv */
// Front end: takes request beats, classifies them and feeds the command queue.
module vha_front #(
	parameter int MAX_SLOTS    = 1024,
	parameter int INDEX_BITS   = 16,
	parameter int VERSION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [31:0] handle_in,
	output logic        cmd_push,
	output vha_pkg::cmd_t cmd_data,
	input  logic        cmd_full
);
	import vha_pkg::*;

	localparam longint unsigned IDX_SPAN   = (64'd1 << INDEX_BITS) - 64'd1;
	localparam longint unsigned SLOT_LIMIT = (longint'(MAX_SLOTS) < IDX_SPAN) ?
		longint'(MAX_SLOTS) : IDX_SPAN;
	localparam int              USED_BITS  = INDEX_BITS + VERSION_BITS;
	localparam logic [63:0]     IDX_MASK   = (64'd1 << INDEX_BITS) - 64'd1;
	localparam logic [63:0]     HI_MASK    = (USED_BITS >= 64) ? 64'd0 :
		~((64'd1 << USED_BITS) - 64'd1);

	logic        vld_s1;
	cmd_t        cmd_s1;
	logic        accept;
	logic        drain;
	logic [63:0] h64;
	cmd_t        cmd_nxt;

	assign full     = vld_s1 && cmd_full;
	assign accept   = push && !full;
	assign drain    = vld_s1 && !cmd_full;
	assign cmd_push = vld_s1;
	assign cmd_data = cmd_s1;
	assign h64      = {32'd0, handle_in};

	// out-of-range index or stray high bits can never match a live handle
	always_comb begin
		cmd_nxt.handle = handle_in;
		if (kind == KIND_CREATE) begin
			cmd_nxt.op = OP_CREATE;
		end else if (((h64 & HI_MASK) != 64'd0) || ((h64 & IDX_MASK) >= SLOT_LIMIT)) begin
			cmd_nxt.op = OP_STALE;
		end else begin
			cmd_nxt.op = OP_DESTROY;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (drain) begin
			vld_s1 <= 1'b0;
		end
	end

endmodule

/* rtl/vha_back.sv */
// Back end: slot table, free stack and the sequencer that carries out commands.
module vha_back #(
	parameter int MAX_SLOTS    = 1024,
	parameter int INDEX_BITS   = 16,
	parameter int VERSION_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  vha_pkg::cmd_t cmd_data,
	output logic          cmd_pop,
	output logic          res_push,
	output vha_pkg::res_t res_data,
	input  logic          res_full
);
	import vha_pkg::*;

	localparam int              AW         = $clog2(MAX_SLOTS);
	localparam int              CW         = $clog2(MAX_SLOTS + 1);
	localparam int              VW         = VERSION_BITS;
	localparam longint unsigned IDX_SPAN   = (64'd1 << INDEX_BITS) - 64'd1;
	localparam longint unsigned SLOT_LIMIT = (longint'(MAX_SLOTS) < IDX_SPAN) ?
		longint'(MAX_SLOTS) : IDX_SPAN;
	localparam logic [CW-1:0]   LIMIT_C    = CW'(SLOT_LIMIT);
	localparam logic [31:0]     IDX_MASK   = 32'((64'd1 << INDEX_BITS) - 64'd1);

	// slot entry: live bit over version; stack entry: index over next version
	logic [VW:0]      slot_mem [MAX_SLOTS];
	logic [AW+VW-1:0] stack_mem [MAX_SLOTS];
	logic [VW:0]      slot_rd_q;
	logic [AW+VW-1:0] stack_rd_q;

	bstate_t        state_q;
	bstate_t        state_d;
	logic [CW-1:0]  slots_used_q;
	logic [CW-1:0]  free_count_q;
	logic [31:0]    handle_q;
	logic [AW-1:0]  idx_q;

	logic           go;
	logic [AW-1:0]  cmd_idx;
	logic           slot_re;
	logic [AW-1:0]  slot_raddr;
	logic           slot_we;
	logic [AW-1:0]  slot_waddr;
	logic [VW:0]    slot_wdata;
	logic           stack_re;
	logic [AW-1:0]  stack_raddr;
	logic           stack_we;
	logic [AW-1:0]  stack_waddr;
	logic [AW+VW-1:0] stack_wdata;
	logic           used_inc;
	logic           free_inc;
	logic           free_dec;
	logic [AW-1:0]  pop_idx;
	logic [VW-1:0]  pop_ver;
	logic [VW-1:0]  chk_ver;
	logic [VW-1:0]  nxt_ver;
	logic           chk_ok;
	logic [CW-1:0]  free_m1;

	assign go      = (state_q == BS_IDLE) && cmd_valid && !res_full;
	assign cmd_idx = AW'(cmd_data.handle & IDX_MASK);
	assign pop_idx = stack_rd_q[AW+VW-1:VW];
	assign pop_ver = stack_rd_q[VW-1:0];
	assign chk_ver = slot_rd_q[VW-1:0];
	assign nxt_ver = chk_ver + VW'(1);
	assign free_m1 = free_count_q - CW'(1);
	assign chk_ok  = slot_rd_q[VW] &&
		(make_handle(32'(idx_q), 32'(chk_ver), INDEX_BITS, VERSION_BITS) == handle_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (go) begin
					if (cmd_data.op == OP_CREATE && free_count_q != '0) begin
						state_d = BS_POP;
					end else if (cmd_data.op == OP_DESTROY &&
							CW'(cmd_idx) < slots_used_q) begin
						state_d = BS_CHECK;
					end
				end
			end
			BS_POP:   state_d = BS_IDLE;
			BS_CHECK: state_d = BS_IDLE;
			default:  state_d = BS_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		res_data    = '{handle: '0, status: STATUS_DONE};
		slot_re     = 1'b0;
		slot_raddr  = cmd_idx;
		slot_we     = 1'b0;
		slot_waddr  = slots_used_q[AW-1:0];
		slot_wdata  = {1'b1, {VW{1'b0}}};
		stack_re    = 1'b0;
		stack_raddr = free_m1[AW-1:0];
		stack_we    = 1'b0;
		stack_waddr = free_count_q[AW-1:0];
		stack_wdata = {idx_q, nxt_ver};
		used_inc    = 1'b0;
		free_inc    = 1'b0;
		free_dec    = 1'b0;
		case (state_q)
			BS_IDLE: begin
				if (go) begin
					cmd_pop = 1'b1;
					case (cmd_data.op)
						OP_CREATE: begin
							if (free_count_q != '0) begin
								stack_re = 1'b1;
								free_dec = 1'b1;
							end else if (slots_used_q < LIMIT_C) begin
								slot_we  = 1'b1;
								used_inc = 1'b1;
								res_push = 1'b1;
								res_data = '{handle: make_handle(32'(slots_used_q), 32'd0,
									INDEX_BITS, VERSION_BITS), status: STATUS_DONE};
							end else begin
								res_push = 1'b1;
								res_data = '{handle: '0, status: STATUS_FULL};
							end
						end
						OP_DESTROY: begin
							if (CW'(cmd_idx) < slots_used_q) begin
								slot_re = 1'b1;
							end else begin
								res_push = 1'b1;
								res_data = '{handle: cmd_data.handle, status: STATUS_STALE};
							end
						end
						default: begin
							res_push = 1'b1;
							res_data = '{handle: cmd_data.handle, status: STATUS_STALE};
						end
					endcase
				end
			end
			BS_POP: begin
				// revive the slot with the version kept on the stack
				slot_we    = 1'b1;
				slot_waddr = pop_idx;
				slot_wdata = {1'b1, pop_ver};
				res_push   = 1'b1;
				res_data   = '{handle: make_handle(32'(pop_idx), 32'(pop_ver),
					INDEX_BITS, VERSION_BITS), status: STATUS_DONE};
			end
			BS_CHECK: begin
				res_push = 1'b1;
				if (chk_ok) begin
					slot_we    = 1'b1;
					slot_waddr = idx_q;
					slot_wdata = {1'b0, nxt_ver};
					stack_we   = 1'b1;
					free_inc   = 1'b1;
					res_data   = '{handle: handle_q, status: STATUS_DONE};
				end else begin
					res_data   = '{handle: handle_q, status: STATUS_STALE};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_waddr] <= stack_wdata;
		end
		if (stack_re) begin
			stack_rd_q <= stack_mem[stack_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			handle_q <= cmd_data.handle;
			idx_q    <= cmd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BS_IDLE;
			slots_used_q <= '0;
			free_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (used_inc) begin
				slots_used_q <= slots_used_q + CW'(1);
			end
			if (free_inc) begin
				free_count_q <= free_count_q + CW'(1);
			end else if (free_dec) begin
				free_count_q <= free_m1;
			end
		end
	end

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for versioned_handle_allocator: predictor, directed and random traffic.
`timescale 1ns / 100ps

module tb_top;
	import vha_pkg::*;

	// Block configuration as instantiated; the slot limit is MAX_SLOTS since
	// 2^INDEX_BITS - 1 is larger.
	localparam int SLOT_LIMIT   = 1024;
	localparam int WATCHDOG_MAX = 1000;   // cycles with no beat on either side
	localparam int PRINT_MAX    = 100;    // keep the log short if things go badly

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        kind;
	logic [31:0] handle_in;
	logic        empty;
	logic        pop;
	logic [31:0] handle_out;
	logic [1:0]  status;

	versioned_handle_allocator #(
		.MAX_SLOTS   (SLOT_LIMIT),
		.INDEX_BITS  (16),
		.VERSION_BITS(16)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.handle_in (handle_in),
		.empty     (empty),
		.pop       (pop),
		.handle_out(handle_out),
		.status    (status)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// Allocator shadow state. Updated at the edge where a request beat is
	// accepted, so it always reflects every request sent so far.
	// ------------------------------------------------------------------
	logic [15:0] ver_tbl   [0:SLOT_LIMIT-1];
	logic        live_tbl  [0:SLOT_LIMIT-1];
	logic [15:0] freed_idx [0:SLOT_LIMIT-1];   // LIFO of freed slot indices
	int          appended;                     // slots ever handed out fresh
	int          freed_depth;

	// Bookkeeping for stimulus only: live indices (swap-remove list) and
	// recently retired handles for replay.
	int          live_list [$];
	int          live_pos  [0:SLOT_LIMIT-1];
	logic [31:0] retired   [$];

	res_t        expected_replies [$];
	int          mismatches;
	bit          idle_off;
	int          pop_hold;
	int          quiet_cycles;

	function automatic logic [31:0] pack_handle(logic [15:0] idx, logic [15:0] ver);
		return {ver, idx};
	endfunction

	// Expected reply for one request; applies its effect on the shadow state.
	function automatic res_t predict_reply(logic k, logic [31:0] h);
		res_t        r;
		logic [15:0] idx;
		int          pos;
		int          last;
		r.handle = '0;
		r.status = STATUS_DONE;
		if (k == KIND_CREATE) begin
			if (freed_depth > 0) begin
				// most recently freed slot comes back with its bumped version
				freed_depth--;
				idx = freed_idx[freed_depth];
				live_tbl[idx] = 1'b1;
				r.handle = pack_handle(idx, ver_tbl[idx]);
				live_pos[idx] = live_list.size();
				live_list.insert(live_list.size(), int'(idx));
			end else if (appended < SLOT_LIMIT) begin
				idx = appended[15:0];
				live_tbl[idx] = 1'b1;
				ver_tbl[idx]  = '0;
				appended++;
				r.handle = pack_handle(idx, '0);
				live_pos[idx] = live_list.size();
				live_list.insert(live_list.size(), int'(idx));
			end else begin
				r.status = STATUS_FULL;
			end
		end else begin
			idx = h[15:0];
			r.handle = h;
			// exact match on the live handle, every bit
			if (int'(idx) < appended && live_tbl[idx] && h == pack_handle(idx, ver_tbl[idx])) begin
				live_tbl[idx] = 1'b0;
				ver_tbl[idx]  = ver_tbl[idx] + 16'd1;   // wraps at 16 bits
				freed_idx[freed_depth] = idx;
				freed_depth++;
				pos  = live_pos[idx];
				last = live_list[live_list.size()-1];
				live_list[pos] = last;
				live_pos[last] = pos;
				live_list.delete(live_list.size()-1);
				retired.insert(retired.size(), h);
				if (retired.size() > 32)
					retired.delete(0);
			end else begin
				r.status = STATUS_STALE;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request side. Called at a falling edge, returns at a falling edge.
	// push stays high across back-to-back beats; it only drops for a gap.
	// ------------------------------------------------------------------
	task automatic issue_request(input logic k, input logic [31:0] h);
		res_t r;
		if (!idle_off && $urandom_range(0, 99) < 12) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		push      <= 1'b1;
		kind      <= k;
		handle_in <= h;
		do @(posedge clk); while (full);
		r = predict_reply(k, h);
		expected_replies.insert(expected_replies.size(), r);
		@(negedge clk);
	endtask

	// Result side: pop with random stall bursts, steady pop in the last part.
	always @(negedge clk) begin
		if (idle_off) begin
			pop <= 1'b1;
		end else if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else if ($urandom_range(0, 99) < 10) begin
			pop <= 1'b0;
			pop_hold = $urandom_range(0, 4);
		end else begin
			pop <= 1'b1;
		end
	end

	// Compare every result beat against the oldest expectation.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && pop && !empty) begin
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= PRINT_MAX)
					$error("unexpected result beat: handle_out %h status %0d", handle_out, status);
			end else begin
				want = expected_replies.pop_front();
				if (handle_out !== want.handle) begin
					mismatches++;
					if (mismatches <= PRINT_MAX)
						$error("handle_out: expected %h, got %h", want.handle, handle_out);
				end
				if (status !== want.status) begin
					mismatches++;
					if (mismatches <= PRINT_MAX)
						$error("status: expected %0d, got %0d", want.status, status);
				end
			end
		end
	end

	// Watchdog: any beat on either side resets the count.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("** versioned_handle_allocator: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked corners on a fresh table: stale on empty, wrong version,
	// stray high bit, dead slot, double destroy, LIFO reuse order.
	task automatic test_directed_cases;
		issue_request(KIND_DESTROY, 32'h0000_0000);   // nothing allocated yet
		issue_request(KIND_DESTROY, 32'hFFFF_FFFF);
		issue_request(KIND_CREATE,  32'hFFFF_FFFF);   // handle_in ignored
		issue_request(KIND_CREATE,  32'h0000_0000);
		issue_request(KIND_DESTROY, pack_handle(16'd0, 16'd1));   // wrong version
		issue_request(KIND_DESTROY, 32'h8000_0000);               // top bit set
		issue_request(KIND_DESTROY, pack_handle(16'd2, 16'd0));   // not yet appended
		issue_request(KIND_DESTROY, pack_handle(16'd0, 16'd0));   // good
		issue_request(KIND_DESTROY, pack_handle(16'd0, 16'd0));   // now dead
		issue_request(KIND_DESTROY, pack_handle(16'd0, 16'd1));   // dead, next version
		issue_request(KIND_CREATE,  32'h0);                       // reuse idx 0, ver 1
		issue_request(KIND_DESTROY, pack_handle(16'd1, 16'd0));
		issue_request(KIND_DESTROY, pack_handle(16'd0, 16'd1));
		issue_request(KIND_CREATE,  32'h0);                       // idx 0 pops first
		issue_request(KIND_CREATE,  32'h0);                       // then idx 1
		issue_request(KIND_CREATE,  32'h0);                       // stack dry: append
		issue_request(KIND_DESTROY, pack_handle(16'hFFFF, 16'hFFFF));
	endtask

	// Append every slot, then hit the full answer, and check that a single
	// free makes room for exactly one more create.
	task automatic test_fill_to_capacity;
		while (!(appended == SLOT_LIMIT && freed_depth == 0))
			issue_request(KIND_CREATE, $urandom);
		repeat (3) issue_request(KIND_CREATE, $urandom);
		issue_request(KIND_DESTROY, pack_handle(16'd1024, 16'd0));   // just past the table
		issue_request(KIND_DESTROY, pack_handle(16'd1023, ver_tbl[1023]));
		issue_request(KIND_CREATE,  $urandom);                       // takes 1023 back
		issue_request(KIND_CREATE,  $urandom);                       // full again
	endtask

	// Mostly legal traffic on live handles with random picks, plus noise:
	// random words, replays of retired handles, single-bit corruptions and
	// indices past the appended range. First half frees more than it takes,
	// second half drains the stack so full answers recur.
	task automatic test_random_churn;
		int          p;
		int          create_pct;
		int          destroy_pct;
		logic [31:0] h;
		logic [15:0] idx;
		for (int n = 0; n < 100; n++) begin
			create_pct  = (n < 50) ? 30 : 50;
			destroy_pct = (n < 50) ? 75 : 80;
			p = $urandom_range(0, 99);
			if (p < create_pct || (p < destroy_pct && live_list.size() == 0)) begin
				issue_request(KIND_CREATE, $urandom);
			end else if (p < destroy_pct) begin
				idx = 16'(live_list[$urandom_range(0, live_list.size() - 1)]);
				issue_request(KIND_DESTROY, pack_handle(idx, ver_tbl[idx]));
			end else begin
				case ($urandom_range(0, 3))
					0: h = $urandom;
					1: h = (retired.size() != 0) ?
						retired[$urandom_range(0, retired.size() - 1)] : $urandom;
					2: begin
						idx = (live_list.size() != 0) ?
							16'(live_list[$urandom_range(0, live_list.size() - 1)]) : 16'd0;
						h = pack_handle(idx, ver_tbl[idx]) ^ (32'd1 << $urandom_range(0, 31));
					end
					default: begin
						h = $urandom;
						h[15:0] = 16'($urandom_range(appended, 16'hFFFF));
					end
				endcase
				issue_request(KIND_DESTROY, h);
			end
		end
	endtask

	// One slot freed and taken back over and over with no idling on either
	// side; the LIFO hands the same slot back with a climbing version.
	task automatic test_steady_reuse;
		logic [15:0] idx;
		idle_off = 1'b1;
		if (live_list.size() == 0)
			issue_request(KIND_CREATE, $urandom);
		idx = 16'(live_list[0]);
		repeat (50) begin
			issue_request(KIND_DESTROY, pack_handle(idx, ver_tbl[idx]));
			issue_request(KIND_CREATE, $urandom);
		end
		issue_request(KIND_DESTROY, pack_handle(idx, ver_tbl[idx]));
	endtask

	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		pop          = 1'b0;
		kind         = KIND_CREATE;
		handle_in    = '0;
		appended     = 0;
		freed_depth  = 0;
		mismatches   = 0;
		idle_off     = 1'b0;
		pop_hold     = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_fill_to_capacity();
		test_random_churn();
		test_steady_reuse();
		push <= 1'b0;

		// drain, then wait for any stray beat to show up
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("** versioned_handle_allocator: PASSED **");
		else
			$display("** versioned_handle_allocator: FAILED **");
		$finish;
	end

endmodule
